// ===== hw/rtl/dsr_pkg.sv =====
package dsr_pkg;

  // Field widths fixed by the item format.
  localparam int REQ_W  = 2;
  localparam int SLOT_W = 4;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 5;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Request codes.
  localparam req_t REQ_WRITE = 2'd0;
  localparam req_t REQ_TEXT  = 2'd1;
  localparam req_t REQ_END   = 2'd2;

  // Pattern byte that matches any text byte.
  localparam byte_t ANY_BYTE = 8'd46;

  // Per-cell control, computed once in the top level for each position.
  typedef struct packed {
    logic head;       // this cell is position zero
    logic wr_en;      // load this cell's pattern element
    logic step;       // a text byte is accepted this cycle
    logic restart;    // an end-of-text item is accepted this cycle
    logic pos_live;   // position index is within the length in use (i <= len)
    logic elem_live;  // element index is within the length in use (i < len)
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/dsr_in_if.sv =====
interface dsr_in_if;
  import dsr_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SLOT_W-1:0]   slot;
  logic [BYTE_W-1:0]   element_byte;
  logic                element_star;
  logic [BYTE_W-1:0]   text_byte;

  modport source (
    output valid, req_type, slot, element_byte, element_star, text_byte,
    input  ready
  );

  modport sink (
    input  valid, req_type, slot, element_byte, element_star, text_byte,
    output ready
  );

endinterface

// ===== hw/rtl/dsr_out_if.sv =====
interface dsr_out_if;

  logic valid;
  logic ready;
  logic matched;

  modport source (
    output valid, matched,
    input  ready
  );

  modport sink (
    input  valid, matched,
    output ready
  );

endinterface

// ===== hw/rtl/dsr_cell.sv =====
module dsr_cell
  import dsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  byte_t      wr_byte,
  input  logic       wr_star,
  input  byte_t      txt_byte,
  input  logic       carry_in,
  input  logic       shift_in,
  output logic       carry_out,
  output logic       shift_out,
  output logic       closed,
  output logic       act
);

  byte_t elem_byte_r;
  logic  elem_star_r;
  logic  act_r;
  logic  act_nxt;
  logic  hit;

  // Position is active after closure if it was active or a starred
  // predecessor may be skipped into it.
  assign closed = ctrl.pos_live & (act_r | carry_in);

  // The element consumes the text byte.
  assign hit = closed & ctrl.elem_live &
               ((elem_byte_r == ANY_BYTE) || (elem_byte_r == txt_byte));

  assign carry_out = closed & ctrl.elem_live & elem_star_r;
  assign shift_out = hit & ~elem_star_r;
  assign act       = act_r;

  // Pattern element storage, loaded by write items.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      elem_byte_r <= wr_byte;
      elem_star_r <= wr_star;
    end
  end

  // Next active flag: a starred element stays, a plain one hands on.
  always_comb begin
    act_nxt = act_r;
    if (ctrl.restart) begin
      act_nxt = ctrl.head;
    end else if (ctrl.step) begin
      act_nxt = (hit & elem_star_r) | shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ctrl.head;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

// ===== hw/rtl/dot_star_regex_matcher_top.sv =====
// Whole-text matcher for a pattern of up to MAX_PATTERN elements, each a byte
// (46 matches any byte) with an optional star. Load elements with write items,
// set cfg_wdata to the number of elements in use, then stream text bytes and
// close each text with an end-of-text item, which returns one matched flag and
// restarts the matcher. The block accepts one item per cycle; any item waits
// only while a previous result sits unread in the output register and the
// receiver is not ready. A row of MAX_PATTERN cells holds the pattern and the
// active positions; the star closure ripples combinationally through the row,
// so the clock period grows with MAX_PATTERN.
// Reset leaves the pattern undefined, the length zero and only position zero
// active; no clearing pass.
module dot_star_regex_matcher_top
  import dsr_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  dsr_in_if.sink           in_chan,
  dsr_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  logic [LEN_W-1:0]       cfg_length_r;
  logic                   out_valid_r;
  logic                   out_matched_r;
  logic                   end_act_r;
  logic                   end_act_nxt;
  logic                   in_acc;
  logic                   acc_write;
  logic                   acc_text;
  logic                   acc_end;
  logic                   end_live;
  logic                   end_closed;
  logic                   matched_nxt;
  logic [MAX_PATTERN:0]   carry;
  logic [MAX_PATTERN:0]   shift;
  logic [MAX_PATTERN-1:0] closed_vec;
  logic [MAX_PATTERN-1:0] at_end_vec;
  logic [MAX_PATTERN-1:0] act_vec;

  // Handshake: the output register parts the two sides.
  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign acc_write     = in_acc & (in_chan.req_type == REQ_WRITE);
  assign acc_text      = in_acc & (in_chan.req_type == REQ_TEXT);
  assign acc_end       = in_acc & (in_chan.req_type == REQ_END);

  // Length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_length_r <= '0;
    end else if (cfg_we) begin
      cfg_length_r <= cfg_wdata;
    end
  end

  assign carry[0] = 1'b0;
  assign shift[0] = 1'b0;

  // Row of cells, one per pattern element.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic       slot_hit;

    if (i < (1 << SLOT_W)) begin : g_slot
      assign slot_hit = (in_chan.slot == SLOT_W'(i));
    end else begin : g_noslot
      assign slot_hit = 1'b0;
    end

    assign ctrl.head      = (i == 0);
    assign ctrl.wr_en     = acc_write & slot_hit;
    assign ctrl.step      = acc_text;
    assign ctrl.restart   = acc_end;
    assign ctrl.pos_live  = (int'(cfg_length_r) >= i);
    assign ctrl.elem_live = (int'(cfg_length_r) > i);
    assign at_end_vec[i]  = (int'(cfg_length_r) == i);

    dsr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .wr_byte   (in_chan.element_byte),
      .wr_star   (in_chan.element_star),
      .txt_byte  (in_chan.text_byte),
      .carry_in  (carry[i]),
      .shift_in  (shift[i]),
      .carry_out (carry[i+1]),
      .shift_out (shift[i+1]),
      .closed    (closed_vec[i]),
      .act       (act_vec[i])
    );
  end

  // Final position, past the last element; a length above the row acts as full.
  assign end_live   = (int'(cfg_length_r) >= MAX_PATTERN);
  assign end_closed = end_live & (end_act_r | carry[MAX_PATTERN]);

  always_comb begin
    end_act_nxt = end_act_r;
    if (acc_end) begin
      end_act_nxt = 1'b0;
    end else if (acc_text) begin
      end_act_nxt = shift[MAX_PATTERN];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_act_r <= 1'b0;
    end else begin
      end_act_r <= end_act_nxt;
    end
  end

  // The answer is the closed flag at the position equal to the length.
  assign matched_nxt = (|(closed_vec & at_end_vec)) | end_closed;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_end) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_end) begin
      out_matched_r <= matched_nxt;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.matched = out_matched_r;

  // An accepted end-of-text item always leaves a result waiting.
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc_end |=> out_valid_r)
    else $error("end-of-text item produced no result");

  // An end-of-text item restarts the active set at position zero alone.
  a_restart_set: assert property (@(posedge clk) disable iff (!rst_n)
    acc_end |=> (act_vec == MAX_PATTERN'(1)) && !end_act_r)
    else $error("active set not restarted after end of text");

  // Input stalls only while a result waits unread.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_valid_r && !out_chan.ready))
    else $error("input stalled without a pending result");

  // Text and write items leave a pending result untouched.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready && !acc_end) |=> $stable(out_matched_r))
    else $error("pending result changed");

endmodule

// ===== tb/dot_star_regex_matcher_top_tb.sv =====
`timescale 1ns / 100ps

module dot_star_regex_matcher_top_tb;
  import dsr_pkg::*;

  localparam int PAT_DEPTH = 16;
  localparam int PHASE_ITEMS = 146;
  localparam int NUM_PHASES = 12;
  localparam int DRAIN_CYCLES = 4;

  // Request code that the block ignores.
  localparam req_t REQ_IGNORED = 2'd3;

  // Byte values that make matches likely.
  localparam byte_t CHAR_A = 8'd97;
  localparam byte_t CHAR_B = 8'd98;
  localparam byte_t CHAR_STAR = 8'd42;

  typedef struct packed {
    req_t                  req;
    logic [SLOT_W-1:0]     slot;
    byte_t                 elem_byte;
    logic                  elem_star;
    byte_t                 text_byte;
  } request_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  dsr_in_if  in_chan ();
  dsr_out_if out_chan ();

  dot_star_regex_matcher_top #(
    .MAX_PATTERN(PAT_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Items waiting to be sent, and match flags waiting to come back.
  request_t request_q[$];
  logic     match_flags_q[$];

  int   send_idle_pct;
  int   recv_stall_pct;
  int   mismatch_count;
  int   items_sent;
  logic in_taken;

  // Predicted pattern table, active positions and length in use.
  byte_t                tbl_byte[PAT_DEPTH];
  logic [PAT_DEPTH-1:0] tbl_star;
  logic [PAT_DEPTH:0]   live_pos;
  logic [LEN_W-1:0]     use_len;

  // Pattern as the stimulus side has written it, used to build matching texts.
  byte_t                gen_byte[PAT_DEPTH];
  logic [PAT_DEPTH-1:0] gen_star;
  int                   gen_len;

  function automatic int used_elems();
    return (use_len > PAT_DEPTH) ? PAT_DEPTH : int'(use_len);
  endfunction

  // Active positions limited to the length in use and closed over starred elements.
  function automatic logic [PAT_DEPTH:0] closed_positions();
    logic [PAT_DEPTH:0] s;
    int n;
    n = used_elems();
    s = '0;
    for (int i = 0; i <= n; i++) s[i] = live_pos[i];
    for (int i = 0; i < n; i++) begin
      if (s[i] && tbl_star[i]) s[i+1] = 1'b1;
    end
    return s;
  endfunction

  // Small alphabet with the wildcard, the literal star, zero and the top byte.
  function automatic byte_t pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CHAR_A;
    if (r < 50) return CHAR_B;
    if (r < 60) return ANY_BYTE;
    if (r < 65) return CHAR_STAR;
    if (r < 68) return 8'd0;
    if (r < 70) return 8'd255;
    return byte_t'($urandom_range(255));
  endfunction

  task automatic push_request(req_t req, logic [SLOT_W-1:0] slot, byte_t eb, logic es,
                              byte_t tb);
    request_t r;
    r.req = req;
    r.slot = slot;
    r.elem_byte = eb;
    r.elem_star = es;
    r.text_byte = tb;
    request_q.push_back(r);
    if (req == REQ_WRITE) begin
      gen_byte[slot] = eb;
      gen_star[slot] = es;
    end
    if (req != REQ_IGNORED) items_sent++;
  endtask

  task automatic push_write(int slot, byte_t eb, logic es);
    push_request(REQ_WRITE, SLOT_W'(slot), eb, es, byte_t'($urandom_range(255)));
  endtask

  task automatic push_text(byte_t tb);
    push_request(REQ_TEXT, SLOT_W'($urandom_range(15)), byte_t'($urandom_range(255)),
                 1'($urandom_range(1)), tb);
  endtask

  task automatic push_end();
    push_request(REQ_END, SLOT_W'($urandom_range(15)), byte_t'($urandom_range(255)),
                 1'($urandom_range(1)), byte_t'($urandom_range(255)));
  endtask

  task automatic push_ignored();
    push_request(REQ_IGNORED, SLOT_W'($urandom_range(15)), byte_t'($urandom_range(255)),
                 1'($urandom_range(1)), byte_t'($urandom_range(255)));
  endtask

  // Wait until every item is sent and every match flag has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (request_q.size() != 0 || in_chan.valid || match_flags_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(int v);
    @(negedge clk);
    cfg_wdata <= LEN_W'(v);
    cfg_we <= 1'b1;
    gen_len = (v > PAT_DEPTH) ? PAT_DEPTH : v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Input driver: a new item goes out once the previous one was taken.
  always @(negedge clk) begin : driver
    request_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = request_q.pop_front();
        in_chan.req_type <= nxt.req;
        in_chan.slot <= nxt.slot;
        in_chan.element_byte <= nxt.elem_byte;
        in_chan.element_star <= nxt.elem_star;
        in_chan.text_byte <= nxt.text_byte;
        in_chan.valid <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random.
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check each result, then predict from each accepted item.
  always @(posedge clk) begin : monitor
    logic want;
    logic [PAT_DEPTH:0] cur;
    logic [PAT_DEPTH:0] nxt;
    int n;
    if (!rst_n) begin
      live_pos = (PAT_DEPTH+1)'(1);
      use_len = '0;
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_chan.valid && in_chan.ready;
      if (cfg_we) use_len = cfg_wdata;

      if (out_chan.valid && out_chan.ready) begin
        if (match_flags_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result matched=%0b with no end of text pending",
                     out_chan.matched);
          mismatch_count++;
        end else begin
          want = match_flags_q.pop_front();
          if (out_chan.matched !== want) begin
            if (mismatch_count < 10)
              $display("matched flag wrong: expected %0b, got %0b", want, out_chan.matched);
            mismatch_count++;
          end
        end
      end

      if (in_chan.valid && in_chan.ready) begin
        n = used_elems();
        cur = closed_positions();
        case (in_chan.req_type)
          REQ_WRITE: begin
            tbl_byte[in_chan.slot] = in_chan.element_byte;
            tbl_star[in_chan.slot] = in_chan.element_star;
          end
          REQ_TEXT: begin
            // A starred element stays put on a match; a plain one moves on.
            nxt = '0;
            for (int i = 0; i < n; i++) begin
              if (cur[i] && (tbl_byte[i] == ANY_BYTE || tbl_byte[i] == in_chan.text_byte)) begin
                if (tbl_star[i]) nxt[i] = 1'b1;
                else nxt[i+1] = 1'b1;
              end
            end
            live_pos = nxt;
          end
          REQ_END: begin
            match_flags_q.push_back(cur[n]);
            live_pos = (PAT_DEPTH+1)'(1);
          end
          default: ;
        endcase
      end
    end
  end

  // Stimulus.
  initial begin
    byte_t text_q[$];
    int lens[NUM_PHASES];
    int reps;
    int pos;
    lens = '{16, 31, 1, 4, 0, 8, 2, 16, 5, 12, 3, 6};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_taken = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.req_type = REQ_WRITE;
    in_chan.slot = '0;
    in_chan.element_byte = '0;
    in_chan.element_star = 1'b0;
    in_chan.text_byte = '0;
    out_chan.ready = 1'b0;
    send_idle_pct = 17;
    recv_stall_pct = 77;
    mismatch_count = 0;
    items_sent = 0;
    gen_len = 0;
    gen_star = '0;
    tbl_star = '0;
    foreach (tbl_byte[i]) tbl_byte[i] = '0;
    foreach (gen_byte[i]) gen_byte[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill every slot so no element is ever read before it is written.
    push_write(0, CHAR_A, 1'b0);
    push_write(1, ANY_BYTE, 1'b0);
    push_write(2, ANY_BYTE, 1'b1);
    push_write(3, 8'd0, 1'b0);
    push_write(4, CHAR_STAR, 1'b0);
    push_write(5, CHAR_B, 1'b1);
    push_write(6, 8'd255, 1'b0);
    for (int s = 7; s < PAT_DEPTH; s++) push_write(s, pick_byte(), 1'($urandom_range(1)));

    // Empty pattern: only the empty text matches.
    push_end();
    push_text(CHAR_A);
    push_end();
    wait_idle();

    // The wildcard never takes the end of the text; the ignored code passes through.
    write_len(2);
    push_text(CHAR_A);
    push_end();
    push_text(CHAR_A);
    push_ignored();
    push_text(8'd0);
    push_end();
    wait_idle();

    // Zero byte and the star byte as plain literals, a starred literal, the top byte.
    write_len(7);
    push_text(CHAR_A);
    push_text(8'd255);
    push_text(8'd0);
    push_text(CHAR_STAR);
    push_text(CHAR_B);
    push_text(8'd255);
    push_end();

    // Random texts, mostly built from the pattern, some broken, some noise.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      if (ph < NUM_PHASES / 3) begin
        send_idle_pct = 17;
        recv_stall_pct = 77;
      end else if (ph < 2 * NUM_PHASES / 3) begin
        send_idle_pct = 77;
        recv_stall_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_len(lens[ph]);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 3))
            push_write($urandom_range(15), pick_byte(), 1'($urandom_range(1)));
        end
        text_q.delete();
        if ($urandom_range(9) < 7) begin
          for (int i = 0; i < gen_len; i++) begin
            reps = gen_star[i] ? $urandom_range(3) : 1;
            repeat (reps) text_q.push_back(gen_byte[i] == ANY_BYTE ? pick_byte() : gen_byte[i]);
          end
          if ($urandom_range(2) == 0) begin
            pos = $urandom_range(text_q.size());
            case ($urandom_range(2))
              0: text_q.insert(pos, pick_byte());
              1: if (pos < text_q.size()) text_q.delete(pos);
              default: if (pos < text_q.size()) text_q[pos] = pick_byte();
            endcase
          end
        end else begin
          repeat ($urandom_range(8)) text_q.push_back(pick_byte());
        end
        foreach (text_q[i]) begin
          push_text(text_q[i]);
          if ($urandom_range(49) == 0) push_ignored();
          if ($urandom_range(99) == 0)
            push_write($urandom_range(15), pick_byte(), 1'($urandom_range(1)));
        end
        push_end();
      end
    end

    wait_idle();
    if (mismatch_count == 0 && match_flags_q.size() == 0)
      $display("dot_star_regex_matcher_top: match");
    else
      $display("dot_star_regex_matcher_top: mismatch");
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("dot_star_regex_matcher_top: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dsr_pkg.sv
hw/rtl/dsr_in_if.sv
hw/rtl/dsr_out_if.sv
hw/rtl/dsr_cell.sv
hw/rtl/dot_star_regex_matcher_top.sv
tb/dot_star_regex_matcher_top_tb.sv
